// ===== hdl/pth_pkg.sv =====
// ----------------------------------------------------------------------------
// pth_pkg
// Shared types, widths and reset constants of the pan/tilt head tracker.
// ----------------------------------------------------------------------------
package pth_pkg;

	// payload widths
	localparam int POS_W  = 16;
	localparam int GAIN_W = 16;
	localparam int MAG_W  = 16;
	localparam int IDX_W  = 3;

	// multiplier and track term widths
	localparam int M_W      = MAG_W + GAIN_W;
	localparam int PROD_W   = 2 * M_W;
	localparam int SQ_SHIFT = 39;
	localparam int TERM_W   = PROD_W - SQ_SHIFT;
	localparam int ACC_W    = TERM_W + 3;

	// home pose defaults, 1/128 degree
	localparam logic signed [POS_W-1:0] PAN_REST_DEF  = 16'sd0;
	localparam logic signed [POS_W-1:0] TILT_REST_DEF = 16'sd1280;

	// register reset values
	localparam logic [GAIN_W-1:0]       P_GAIN_RST     = 16'd6554;
	localparam logic [GAIN_W-1:0]       D_GAIN_RST     = 16'd14418;
	localparam logic signed [POS_W-1:0] PAN_UPPER_RST  = 16'sd8960;
	localparam logic signed [POS_W-1:0] PAN_LOWER_RST  = -16'sd8960;
	localparam logic signed [POS_W-1:0] TILT_UPPER_RST = 16'sd5120;
	localparam logic signed [POS_W-1:0] TILT_LOWER_RST = -16'sd3200;

	// command codes
	typedef enum logic [1:0] {
		KIND_TRACK,
		KIND_MOVE,
		KIND_OFFSET,
		KIND_INIT
	} kind_t;

	// register map
	typedef enum logic [IDX_W-1:0] {
		REG_PAN_P_GAIN,
		REG_PAN_D_GAIN,
		REG_TILT_P_GAIN,
		REG_TILT_D_GAIN,
		REG_PAN_UPPER,
		REG_PAN_LOWER,
		REG_TILT_UPPER,
		REG_TILT_LOWER
	} reg_idx_t;

	// per-axis settings handed to a lane
	typedef struct packed {
		logic [GAIN_W-1:0]       p_gain;
		logic [GAIN_W-1:0]       d_gain;
		logic signed [POS_W-1:0] upper;
		logic signed [POS_W-1:0] lower;
	} axis_cfg_t;

	// lane status toward the merge stage
	typedef struct packed {
		logic                    done;
		logic signed [POS_W-1:0] pos;
	} lane_status_t;

endpackage

// ===== hdl/pth_if.sv =====
// ----------------------------------------------------------------------------
// pth interfaces
// Valid/ready channels of the head tracker: command, angle result, config.
// ----------------------------------------------------------------------------

// command channel
interface pth_cmd_if import pth_pkg::*; ();
	logic                    valid;
	logic                    ready;
	kind_t                   kind;
	logic signed [POS_W-1:0] pan_value;
	logic signed [POS_W-1:0] tilt_value;

	modport source (output valid, kind, pan_value, tilt_value, input ready);
	modport sink   (input valid, kind, pan_value, tilt_value, output ready);
endinterface

// angle result channel
interface pth_pos_if import pth_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pan_out;
	logic signed [POS_W-1:0] tilt_out;

	modport source (output valid, pan_out, tilt_out, input ready);
	modport sink   (input valid, pan_out, tilt_out, output ready);
endinterface

// register write channel
interface pth_cfg_if import pth_pkg::*; ();
	logic              valid;
	logic              ready;
	reg_idx_t          index;
	logic [POS_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pan_tilt_head_tracker.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_head_tracker
// Two-axis head aiming controller: track, move to, move by and initialize
// commands, each answered with the clamped pan and tilt angles.
//
// channel  dir  payload                       handshake
// cmd      in   kind, pan_value, tilt_value   valid / ready
// pos      out  pan_out, tilt_out             valid / ready
// cfg      in   index, data                   valid / ready (always ready)
//
// A track command runs four multiplies in turn on the one multiplier of each
// lane before the clamp; move, offset and initialize commands go straight to
// the clamp. The result waits in an output register; a new command is taken
// while it waits.
// Reset puts both angles at home without limit clamp and clears the errors.
// ----------------------------------------------------------------------------
module pan_tilt_head_tracker import pth_pkg::*; #(
	parameter logic signed [POS_W-1:0] PAN_REST  = PAN_REST_DEF,
	parameter logic signed [POS_W-1:0] TILT_REST = TILT_REST_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	pth_cmd_if.sink    cmd,
	pth_pos_if.source  pos,
	pth_cfg_if.sink    cfg
);

	axis_cfg_t    pan_cfg_q;
	axis_cfg_t    tilt_cfg_q;
	lane_status_t pan_st;
	lane_status_t tilt_st;
	logic         cmd_accept;

	assign cmd_accept = cmd.valid & cmd.ready;
	assign cfg.ready  = 1'b1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_cfg_q.p_gain  <= P_GAIN_RST;
			pan_cfg_q.d_gain  <= D_GAIN_RST;
			tilt_cfg_q.p_gain <= P_GAIN_RST;
			tilt_cfg_q.d_gain <= D_GAIN_RST;
			pan_cfg_q.upper   <= PAN_UPPER_RST;
			pan_cfg_q.lower   <= PAN_LOWER_RST;
			tilt_cfg_q.upper  <= TILT_UPPER_RST;
			tilt_cfg_q.lower  <= TILT_LOWER_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_PAN_P_GAIN:  pan_cfg_q.p_gain  <= cfg.data;
				REG_PAN_D_GAIN:  pan_cfg_q.d_gain  <= cfg.data;
				REG_TILT_P_GAIN: tilt_cfg_q.p_gain <= cfg.data;
				REG_TILT_D_GAIN: tilt_cfg_q.d_gain <= cfg.data;
				REG_PAN_UPPER:   pan_cfg_q.upper   <= cfg.data;
				REG_PAN_LOWER:   pan_cfg_q.lower   <= cfg.data;
				REG_TILT_UPPER:  tilt_cfg_q.upper  <= cfg.data;
				REG_TILT_LOWER:  tilt_cfg_q.lower  <= cfg.data;
			endcase
		end
	end

	// pan lane
	pth_axis #(
		.HOME (PAN_REST)
	) u_pan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd_accept),
		.kind   (cmd.kind),
		.value  (cmd.pan_value),
		.cfg    (pan_cfg_q),
		.status (pan_st)
	);

	// tilt lane
	pth_axis #(
		.HOME (TILT_REST)
	) u_tilt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd_accept),
		.kind   (cmd.kind),
		.value  (cmd.tilt_value),
		.cfg    (tilt_cfg_q),
		.status (tilt_st)
	);

	// result merge and output register
	pth_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (cmd_accept),
		.in_ready  (cmd.ready),
		.pan_st    (pan_st),
		.tilt_st   (tilt_st),
		.out_valid (pos.valid),
		.out_ready (pos.ready),
		.pan_out   (pos.pan_out),
		.tilt_out  (pos.tilt_out)
	);

endmodule

// ===== hdl/pth_axis.sv =====
// ----------------------------------------------------------------------------
// pth_axis
// One axis lane: holds angle and last error, runs the track update on a
// single shared 32x32 multiplier, then saturates and clamps to the limits.
// ----------------------------------------------------------------------------
module pth_axis import pth_pkg::*; #(
	parameter logic signed [POS_W-1:0] HOME = '0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  kind_t                   kind,
	input  logic signed [POS_W-1:0] value,
	input  axis_cfg_t               cfg,
	output lane_status_t            status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P1,
		ST_MUL_P2,
		ST_ADD_P,
		ST_MUL_D2,
		ST_ADD_D,
		ST_CLAMP
	} state_t;

	localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-(2 ** (POS_W - 1)));
	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (POS_W - 1) - 1);

	state_t                  state_q;
	logic signed [POS_W-1:0] pos_q;
	logic signed [POS_W-1:0] last_err_q;
	logic                    done_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [PROD_W-1:0]       prod_q;
	logic [MAG_W-1:0]        p_mag_q;
	logic [MAG_W-1:0]        d_mag_q;
	logic                    p_neg_q;
	logic                    d_neg_q;

	logic [MAG_W-1:0]        p_mag;
	logic signed [POS_W:0]   d_err;
	logic [POS_W:0]          d_err_neg;
	logic [MAG_W-1:0]        d_mag;
	logic [M_W-1:0]          mul_a;
	logic [M_W-1:0]          mul_b;
	logic [PROD_W-1:0]       prod_d;
	logic signed [ACC_W-1:0] term;
	logic signed [POS_W-1:0] sat;
	logic signed [POS_W-1:0] clamped;

	// error magnitudes and error change
	assign p_mag     = value[POS_W-1] ? MAG_W'(-value) : MAG_W'(value);
	assign d_err     = {value[POS_W-1], value} - {last_err_q[POS_W-1], last_err_q};
	assign d_err_neg = -d_err;
	assign d_mag     = d_err[POS_W] ? d_err_neg[MAG_W-1:0] : d_err[MAG_W-1:0];

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_MUL_P1: begin
				mul_a = M_W'(p_mag_q);
				mul_b = M_W'(cfg.p_gain);
			end
			ST_ADD_P: begin
				mul_a = M_W'(d_mag_q);
				mul_b = M_W'(cfg.d_gain);
			end
			default: begin
				mul_a = prod_q[M_W-1:0];
				mul_b = prod_q[M_W-1:0];
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// truncated square term
	assign term = ACC_W'(prod_q[PROD_W-1:SQ_SHIFT]);

	// saturate to 16 bits, then clamp, lower test first
	always_comb begin
		if (acc_q < SAT_MIN) begin
			sat = SAT_MIN[POS_W-1:0];
		end else if (acc_q > SAT_MAX) begin
			sat = SAT_MAX[POS_W-1:0];
		end else begin
			sat = acc_q[POS_W-1:0];
		end
		if (sat < cfg.lower) begin
			clamped = cfg.lower;
		end else if (sat > cfg.upper) begin
			clamped = cfg.upper;
		end else begin
			clamped = sat;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= HOME;
			last_err_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						unique case (kind)
							KIND_TRACK: begin
								p_mag_q    <= p_mag;
								p_neg_q    <= value[POS_W-1];
								d_mag_q    <= d_mag;
								d_neg_q    <= d_err[POS_W];
								last_err_q <= value;
								acc_q      <= ACC_W'(pos_q);
								state_q    <= ST_MUL_P1;
							end
							KIND_MOVE: begin
								acc_q   <= ACC_W'(value);
								state_q <= ST_CLAMP;
							end
							KIND_OFFSET: begin
								acc_q   <= ACC_W'(pos_q) + ACC_W'(value);
								state_q <= ST_CLAMP;
							end
							KIND_INIT: begin
								acc_q      <= ACC_W'(HOME);
								last_err_q <= '0;
								state_q    <= ST_CLAMP;
							end
						endcase
					end
				end
				ST_MUL_P1: begin
					prod_q  <= prod_d;
					state_q <= ST_MUL_P2;
				end
				ST_MUL_P2: begin
					prod_q  <= prod_d;
					state_q <= ST_ADD_P;
				end
				ST_ADD_P: begin
					acc_q   <= p_neg_q ? acc_q - term : acc_q + term;
					prod_q  <= prod_d;
					state_q <= ST_MUL_D2;
				end
				ST_MUL_D2: begin
					prod_q  <= prod_d;
					state_q <= ST_ADD_D;
				end
				ST_ADD_D: begin
					acc_q   <= d_neg_q ? acc_q - term : acc_q + term;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					pos_q   <= clamped;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign status.done = done_q;
	assign status.pos  = pos_q;

endmodule

// ===== hdl/pth_merge.sv =====
// ----------------------------------------------------------------------------
// pth_merge
// Joins the two lane results into one output word and paces the command
// side: one command in flight, result held in an output register.
// ----------------------------------------------------------------------------
module pth_merge import pth_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_accept,
	output logic                    in_ready,
	input  lane_status_t            pan_st,
	input  lane_status_t            tilt_st,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [POS_W-1:0] pan_out,
	output logic signed [POS_W-1:0] tilt_out
);

	logic                    busy_q;
	logic                    got_pan_q;
	logic                    got_tilt_q;
	logic                    out_valid_q;
	logic signed [POS_W-1:0] pan_q;
	logic signed [POS_W-1:0] tilt_q;

	logic got_pan;
	logic got_tilt;
	logic load;

	// both lanes finished and the output register is free
	assign got_pan  = got_pan_q | pan_st.done;
	assign got_tilt = got_tilt_q | tilt_st.done;
	assign load     = got_pan & got_tilt & (!out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			got_pan_q   <= 1'b0;
			got_tilt_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pan_q       <= pan_st.pos;
				tilt_q      <= tilt_st.pos;
				out_valid_q <= 1'b1;
				got_pan_q   <= 1'b0;
				got_tilt_q  <= 1'b0;
				busy_q      <= 1'b0;
			end else begin
				got_pan_q  <= got_pan;
				got_tilt_q <= got_tilt;
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
				if (in_accept) begin
					busy_q <= 1'b1;
				end
			end
		end
	end

	assign in_ready  = !busy_q;
	assign out_valid = out_valid_q;
	assign pan_out   = pan_q;
	assign tilt_out  = tilt_q;

endmodule

// ===== bench/pth_angle_checker.sv =====
// ----------------------------------------------------------------------------
// pth_angle_checker
// Watches the command, angle and register channels of the head tracker,
// keeps its own copy of the aiming state and settings, predicts the clamped
// angles of each accepted command and compares them with the angle words.
// ----------------------------------------------------------------------------
module pth_angle_checker import pth_pkg::*; #(
	parameter logic signed [POS_W-1:0] PAN_REST  = PAN_REST_DEF,
	parameter logic signed [POS_W-1:0] TILT_REST = TILT_REST_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pth_cmd_if          cmd,
	pth_pos_if          pos,
	pth_cfg_if          cfg,
	output int unsigned mismatches,
	output int unsigned angles_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [POS_W-1:0] pan;
		logic signed [POS_W-1:0] tilt;
	} angle_pair_t;

	angle_pair_t             angle_q[$];
	axis_cfg_t               pan_cfg;
	axis_cfg_t               tilt_cfg;
	logic signed [POS_W-1:0] pan_angle;
	logic signed [POS_W-1:0] tilt_angle;
	logic signed [POS_W-1:0] pan_err_prev;
	logic signed [POS_W-1:0] tilt_err_prev;
	int unsigned             fail_total = 0;

	// signed square of error times gain, truncated
	function automatic longint gain_square(longint err, logic [GAIN_W-1:0] gain);
		logic [63:0] mag;
		logic [63:0] scaled;
		mag = (err < 0) ? -err : err;
		scaled = mag * gain;
		mag = (scaled * scaled) >> SQ_SHIFT;
		return (err < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	// saturate to 16 bits, then to the axis limits (lower test first)
	function automatic logic signed [POS_W-1:0] limit_angle(longint v,
			logic signed [POS_W-1:0] lo, logic signed [POS_W-1:0] hi);
		if (v < -32768)
			v = -32768;
		if (v > 32767)
			v = 32767;
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v[POS_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		angle_pair_t want;
		longint      pan_sum;
		longint      tilt_sum;
		if (!arst_n) begin
			pan_cfg       = '{P_GAIN_RST, D_GAIN_RST, PAN_UPPER_RST, PAN_LOWER_RST};
			tilt_cfg      = '{P_GAIN_RST, D_GAIN_RST, TILT_UPPER_RST, TILT_LOWER_RST};
			pan_angle     = PAN_REST;
			tilt_angle    = TILT_REST;
			pan_err_prev  = '0;
			tilt_err_prev = '0;
			angle_q.delete();
			mismatches <= fail_total;
			angles_due <= 0;
		end else begin
			// register word
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_PAN_P_GAIN:  pan_cfg.p_gain  = cfg.data;
					REG_PAN_D_GAIN:  pan_cfg.d_gain  = cfg.data;
					REG_TILT_P_GAIN: tilt_cfg.p_gain = cfg.data;
					REG_TILT_D_GAIN: tilt_cfg.d_gain = cfg.data;
					REG_PAN_UPPER:   pan_cfg.upper   = cfg.data;
					REG_PAN_LOWER:   pan_cfg.lower   = cfg.data;
					REG_TILT_UPPER:  tilt_cfg.upper  = cfg.data;
					REG_TILT_LOWER:  tilt_cfg.lower  = cfg.data;
					default: ;
				endcase
			end

			// angle word against the oldest prediction
			if (pos.valid && pos.ready) begin
				if (angle_q.size() == 0) begin
					$error("pan_out/tilt_out: unexpected word, expected none, got %0d / %0d",
						pos.pan_out, pos.tilt_out);
					fail_total++;
				end else begin
					want = angle_q.pop_front();
					if (pos.pan_out !== want.pan) begin
						$error("pan_out: expected %0d, got %0d", want.pan, pos.pan_out);
						fail_total++;
					end
					if (pos.tilt_out !== want.tilt) begin
						$error("tilt_out: expected %0d, got %0d", want.tilt, pos.tilt_out);
						fail_total++;
					end
				end
			end

			// command word: advance the predicted head state
			if (cmd.valid && cmd.ready) begin
				case (cmd.kind)
					KIND_TRACK: begin
						// error change taken before the stored error is replaced
						pan_sum = longint'(pan_angle)
							+ gain_square(longint'(cmd.pan_value), pan_cfg.p_gain)
							+ gain_square(longint'(cmd.pan_value) - longint'(pan_err_prev),
								pan_cfg.d_gain);
						tilt_sum = longint'(tilt_angle)
							+ gain_square(longint'(cmd.tilt_value), tilt_cfg.p_gain)
							+ gain_square(longint'(cmd.tilt_value) - longint'(tilt_err_prev),
								tilt_cfg.d_gain);
						pan_err_prev  = cmd.pan_value;
						tilt_err_prev = cmd.tilt_value;
					end
					KIND_MOVE: begin
						pan_sum  = longint'(cmd.pan_value);
						tilt_sum = longint'(cmd.tilt_value);
					end
					KIND_OFFSET: begin
						pan_sum  = longint'(pan_angle) + longint'(cmd.pan_value);
						tilt_sum = longint'(tilt_angle) + longint'(cmd.tilt_value);
					end
					default: begin
						pan_sum       = longint'(PAN_REST);
						tilt_sum      = longint'(TILT_REST);
						pan_err_prev  = '0;
						tilt_err_prev = '0;
					end
				endcase
				pan_angle  = limit_angle(pan_sum, pan_cfg.lower, pan_cfg.upper);
				tilt_angle = limit_angle(tilt_sum, tilt_cfg.lower, tilt_cfg.upper);
				angle_q.push_back('{pan_angle, tilt_angle});
			end

			mismatches <= fail_total;
			angles_due <= angle_q.size();
		end
	end

endmodule

// ===== bench/pan_tilt_head_tracker_tb.sv =====
// ----------------------------------------------------------------------------
// pan_tilt_head_tracker_tb
// Drives head commands and register writes into the tracker under random
// sender gaps and receiver stalls; the angle checker predicts and compares.
// ----------------------------------------------------------------------------
module pan_tilt_head_tracker_tb import pth_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 250000;

	logic        clk = 1'b0;
	logic        arst_n;
	int unsigned send_gap_pct;
	int unsigned stall_pct;
	int unsigned mismatches;
	int unsigned angles_due;
	int unsigned cycles = 0;

	pth_cmd_if cmd_ch ();
	pth_pos_if pos_ch ();
	pth_cfg_if cfg_ch ();

	pan_tilt_head_tracker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.pos    (pos_ch),
		.cfg    (cfg_ch)
	);

	pth_angle_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd_ch),
		.pos        (pos_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.angles_due (angles_due)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// angle receiver with random stalls
	initial begin
		pos_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			pos_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// mostly small angles, some mid-range, some full range, some extremes
	function automatic logic signed [POS_W-1:0] random_angle();
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return 16'($urandom_range(1023)) - 16'sd512;
			5, 6, 7:       return 16'($urandom);
			8: begin
				case ($urandom_range(3))
					0:       return 16'sh8000;
					1:       return 16'sh7fff;
					2:       return -16'sd1;
					default: return 16'sd0;
				endcase
			end
			default:       return 16'($urandom_range(8191)) - 16'sd4096;
		endcase
	endfunction

	// one command word; valid stays high unless a gap is taken
	task automatic issue_command(kind_t k, logic signed [POS_W-1:0] pan_v,
			logic signed [POS_W-1:0] tilt_v);
		if ($urandom_range(99) < send_gap_pct) begin
			cmd_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_gap_pct);
		end
		cmd_ch.valid      <= 1'b1;
		cmd_ch.kind       <= k;
		cmd_ch.pan_value  <= pan_v;
		cmd_ch.tilt_value <= tilt_v;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
	endtask

	// stop sending until every predicted angle word has come back
	task automatic wait_for_angles();
		cmd_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (angles_due != 0);
	endtask

	task automatic write_register(reg_idx_t idx, logic [POS_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
	endtask

	// full register set, written while the head is idle
	task automatic program_head(logic [GAIN_W-1:0] pan_p, logic [GAIN_W-1:0] pan_d,
			logic [GAIN_W-1:0] tilt_p, logic [GAIN_W-1:0] tilt_d,
			logic signed [POS_W-1:0] pan_hi, logic signed [POS_W-1:0] pan_lo,
			logic signed [POS_W-1:0] tilt_hi, logic signed [POS_W-1:0] tilt_lo);
		wait_for_angles();
		write_register(REG_PAN_P_GAIN, pan_p);
		write_register(REG_PAN_D_GAIN, pan_d);
		write_register(REG_TILT_P_GAIN, tilt_p);
		write_register(REG_TILT_D_GAIN, tilt_d);
		write_register(REG_PAN_UPPER, pan_hi);
		write_register(REG_PAN_LOWER, pan_lo);
		write_register(REG_TILT_UPPER, tilt_hi);
		write_register(REG_TILT_LOWER, tilt_lo);
		cfg_ch.valid <= 1'b0;
	endtask

	// random gains and limits, limits possibly inverted
	task automatic program_random(bit inverted_ok);
		logic signed [POS_W-1:0] pan_hi, pan_lo, tilt_hi, tilt_lo;
		if (inverted_ok) begin
			pan_hi  = 16'($urandom);
			pan_lo  = 16'($urandom);
			tilt_hi = 16'($urandom);
			tilt_lo = 16'($urandom);
		end else begin
			pan_hi  = 16'($urandom_range(32767));
			pan_lo  = 16'(-$urandom_range(32768));
			tilt_hi = 16'($urandom_range(32767));
			tilt_lo = 16'(-$urandom_range(32768));
		end
		program_head(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			pan_hi, pan_lo, tilt_hi, tilt_lo);
	endtask

	// random command mix, now and then a full drain
	task automatic random_command();
		int unsigned pick;
		kind_t       k;
		pick = $urandom_range(99);
		if (pick < 55)
			k = KIND_TRACK;
		else if (pick < 70)
			k = KIND_MOVE;
		else if (pick < 88)
			k = KIND_OFFSET;
		else
			k = KIND_INIT;
		if ($urandom_range(49) == 0)
			wait_for_angles();
		issue_command(k, random_angle(), random_angle());
	endtask

	// stimulus and verdict
	initial begin
		send_gap_pct = 11;
		stall_pct    = 74;
		arst_n            <= 1'b0;
		cmd_ch.valid      <= 1'b0;
		cmd_ch.kind       <= KIND_TRACK;
		cmd_ch.pan_value  <= '0;
		cmd_ch.tilt_value <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.index      <= REG_PAN_P_GAIN;
		cfg_ch.data       <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: tracking, steady error, extremes, moves, offsets, home
		issue_command(KIND_TRACK, 16'sd0, 16'sd0);
		issue_command(KIND_TRACK, 16'sd1000, -16'sd1000);
		issue_command(KIND_TRACK, 16'sd1000, -16'sd1000);
		issue_command(KIND_TRACK, 16'sh8000, 16'sh7fff);
		issue_command(KIND_TRACK, 16'sh7fff, 16'sh8000);
		issue_command(KIND_MOVE, 16'sd20000, -16'sd20000);
		issue_command(KIND_MOVE, -16'sd100, 16'sd200);
		issue_command(KIND_OFFSET, 16'sh7fff, 16'sh7fff);
		issue_command(KIND_OFFSET, 16'sh8000, 16'sh8000);
		issue_command(KIND_INIT, 16'sh7fff, 16'sh8000);
		issue_command(KIND_TRACK, 16'sd500, 16'sd500);

		// full gains, full-range limits: wide sums saturate to 16 bits
		program_head(16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
		issue_command(KIND_MOVE, 16'sh7fff, 16'sh7fff);
		issue_command(KIND_OFFSET, 16'sh7fff, 16'sh7fff);
		issue_command(KIND_MOVE, 16'sh8000, 16'sh8000);
		issue_command(KIND_OFFSET, 16'sh8000, 16'sh8000);
		issue_command(KIND_TRACK, 16'sh7fff, 16'sh7fff);
		issue_command(KIND_TRACK, 16'sh8000, 16'sh8000);
		issue_command(KIND_INIT, 16'sd0, 16'sd0);

		// zero gains, inverted pan limits, tilt limits below home
		program_head(16'h0000, 16'h0000, 16'h0000, 16'h0000,
			-16'sd1000, 16'sd1000, 16'sd1000, -16'sd1000);
		issue_command(KIND_TRACK, 16'sd5000, 16'sd5000);
		issue_command(KIND_MOVE, 16'sd0, 16'sd2000);
		issue_command(KIND_MOVE, -16'sd5000, -16'sd5000);
		issue_command(KIND_INIT, 16'sd0, 16'sd0);
		issue_command(KIND_OFFSET, 16'sd1, 16'sd1);

		// random segments, each under its own settings and idling
		for (int seg = 0; seg < 5; seg++) begin
			if (seg < 2) begin
				send_gap_pct = 11;
				stall_pct    = 74;
			end else if (seg < 4) begin
				send_gap_pct = 74;
				stall_pct    = 11;
			end else begin
				send_gap_pct = 0;
				stall_pct    = 0;
			end
			if (seg == 2)
				program_head(P_GAIN_RST, D_GAIN_RST, P_GAIN_RST, D_GAIN_RST,
					PAN_UPPER_RST, PAN_LOWER_RST, TILT_UPPER_RST, TILT_LOWER_RST);
			else
				program_random(seg == 1 || seg == 3);
			repeat (100) random_command();
		end

		// drain, then let the pipeline settle
		wait_for_angles();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && angles_due == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== pan_tilt_head_tracker.f =====
hdl/pth_pkg.sv
hdl/pth_if.sv
hdl/pth_axis.sv
hdl/pth_merge.sv
hdl/pan_tilt_head_tracker.sv
bench/pth_angle_checker.sv
bench/pan_tilt_head_tracker_tb.sv
